[hdl/vppi_pkg.sv]
// Package for the voxel point palette indexer: widths, defaults, FSM states and chain link type.
`timescale 1ns / 1ps

package vppi_pkg;

  // Field widths
  localparam int POS_W   = 16;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 24;
  localparam int IDX_W   = 8;
  localparam int CHUNK_W = 11;
  localparam int VOX_W   = 15;

  // Divider widths: biased offset and remainder (chunk size is at most 256)
  localparam int DIV_W = 18;
  localparam int REM_W = 8;

  // Divider steps: reciprocal product first, then the remainder
  localparam int DIV_STEPS = 2;

  // Defaults for top-level parameters
  localparam int CHUNK_SIZE_DEF    = 32;
  localparam int PALETTE_SLOTS_DEF = 255;

  // Action codes
  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_PLACE   = 1'b1;

  // Status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCALE,
    ST_DONE
  } state_t;

  // Search result handed from one palette cell to the next
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } link_t;

endpackage

[hdl/vppi_if.sv]
// Valid/ready channel interfaces for the point input and the indexed result.
`timescale 1ns / 1ps

interface vppi_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [15:0]       pos_x;
  logic signed [15:0]       pos_y;
  logic signed [15:0]       pos_z;
  logic [7:0]               red;
  logic [7:0]               green;
  logic [7:0]               blue;

  modport source (output valid, action, pos_x, pos_y, pos_z, red, green, blue,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, red, green, blue,
                  output ready);
endinterface

interface vppi_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  color_index;
  logic [10:0] chunk_x;
  logic [10:0] chunk_y;
  logic [10:0] chunk_z;
  logic [14:0] voxel_index;

  modport source (output valid, status, color_index, chunk_x, chunk_y, chunk_z,
                  voxel_index, input ready);
  modport sink   (input valid, status, color_index, chunk_x, chunk_y, chunk_z,
                  voxel_index, output ready);
endinterface

[hdl/vppi_cell.sv]
// One palette cell: holds a slot color, compares it to the probe, passes the search result on.
`timescale 1ns / 1ps

module vppi_cell #(
  parameter int SLOT = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [vppi_pkg::COLOR_W-1:0]  probe,
  input  logic [vppi_pkg::IDX_W-1:0]    used,
  input  logic                          wr_en,
  input  vppi_pkg::link_t               link_in,
  output vppi_pkg::link_t               link_out
);

  logic [vppi_pkg::COLOR_W-1:0] color_r;
  vppi_pkg::link_t              link_r;
  vppi_pkg::link_t              link_nxt;
  logic                         match;

  // Only slots already in use take part in the search
  assign match = (vppi_pkg::IDX_W'(SLOT) < used) && (color_r == probe);

  // Keep the earliest hit, else claim this slot on a match
  always_comb begin
    link_nxt.hit = link_in.hit | match;
    link_nxt.idx = link_in.hit ? link_in.idx : vppi_pkg::IDX_W'(SLOT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  // Store the probe color when this slot is appended
  always_ff @(posedge clk) begin
    if (wr_en) begin
      color_r <= probe;
    end
  end

  assign link_out = link_r;

endmodule

[hdl/vppi_div.sv]
// Divider by the chunk size: reciprocal product for the quotient, then the remainder.
`timescale 1ns / 1ps

module vppi_div #(
  parameter int CHUNK_SIZE = vppi_pkg::CHUNK_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [vppi_pkg::DIV_W-1:0]   dividend,
  output logic [vppi_pkg::DIV_W-1:0]   quotient,
  output logic [vppi_pkg::REM_W-1:0]   remainder
);

  localparam int DIV_W = vppi_pkg::DIV_W;
  localparam int REM_W = vppi_pkg::REM_W;
  // Scale of the reciprocal: exact floor quotient for any dividend below 2^DIV_W
  // and any divisor from 2 up to 2^REM_W
  localparam int SHIFT = DIV_W + REM_W;
  localparam logic [SHIFT-1:0] RECIP = SHIFT'(((1 << SHIFT) + CHUNK_SIZE - 1) / CHUNK_SIZE);
  localparam logic [REM_W-1:0] DIVISOR_LO = REM_W'(CHUNK_SIZE % (1 << REM_W));

  logic [DIV_W-1:0] dvd_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] quo_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;

  // Multiply by the reciprocal and keep the integer part; the remainder is below
  // the divisor, so the low bits of dividend minus quotient times divisor suffice
  always_comb begin
    quo_nxt = DIV_W'(({{SHIFT{1'b0}}, dvd_r} * {{DIV_W{1'b0}}, RECIP}) >> SHIFT);
    rem_nxt = dvd_r[REM_W-1:0] - (quo_r[REM_W-1:0] * DIVISOR_LO);
  end

  // Load the dividend, then settle the quotient and the remainder over two steps
  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hdl/voxel_point_palette_indexer_core.sv]
// Top level of the voxel point palette indexer: controller, minima, divider trio, palette chain.
`timescale 1ns / 1ps

// Points arrive one at a time. A measure item (action 0) folds x, y and z into the running
// minima and returns an all-zero result from the done state. A place item (action 1)
// broadcasts its RGB color to a row of PALETTE_SLOTS-1 palette cells whose search result
// ripples one cell per cycle, while three dividers take the offsets from the minima apart
// into chunk coordinate and in-chunk remainder by a reciprocal multiply, quotient first and
// remainder second. A place item then holds the block through the run state, which covers
// the cell row and the divider steps, then the scale state and the done state. A new color is
// appended to the next free slot; once the palette is full an unknown color returns status 1
// with color index 0. The result sits in an output register; the next item is accepted once
// the previous one has been loaded there.
// Palette slots need no clearing after reset: only slots below the fill count are compared.
module voxel_point_palette_indexer_core #(
  parameter int CHUNK_SIZE    = vppi_pkg::CHUNK_SIZE_DEF,
  parameter int PALETTE_SLOTS = vppi_pkg::PALETTE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vppi_in_if.sink    in_chan,
  vppi_out_if.source out_chan
);

  localparam int IDX_W   = vppi_pkg::IDX_W;
  localparam int DIV_W   = vppi_pkg::DIV_W;
  localparam int POS_W   = vppi_pkg::POS_W;
  localparam int VOX_W   = vppi_pkg::VOX_W;
  localparam int CHUNK_W = vppi_pkg::CHUNK_W;
  localparam int REM_W   = vppi_pkg::REM_W;
  localparam int NCELLS  = PALETTE_SLOTS - 1;
  localparam int RUN_CYCLES = (NCELLS > vppi_pkg::DIV_STEPS) ? NCELLS : vppi_pkg::DIV_STEPS;
  // Bias that makes every offset non-negative and is a multiple of the chunk size
  localparam int BIAS_Q  = (65536 + CHUNK_SIZE - 1) / CHUNK_SIZE;
  localparam int BIAS    = BIAS_Q * CHUNK_SIZE;
  localparam logic [VOX_W-1:0] CS_M  = VOX_W'(CHUNK_SIZE % 32768);
  localparam logic [VOX_W-1:0] CS2_M = VOX_W'((CHUNK_SIZE * CHUNK_SIZE) % 32768);

  vppi_pkg::state_t state_r, state_nxt;

  logic [7:0]                    cnt_r;
  logic                          place_r;
  logic [vppi_pkg::COLOR_W-1:0]  probe_r;
  logic [IDX_W-1:0]              used_r;
  logic signed [POS_W-1:0]       min_x_r, min_y_r, min_z_r;

  logic in_fire, run_last, out_free;
  logic div_load, div_step, commit, append;

  // Offsets and biased dividends
  logic [POS_W:0]   off_x, off_y, off_z;
  logic [DIV_W-1:0] dvd_x, dvd_y, dvd_z;
  logic [DIV_W-1:0] quo_x, quo_y, quo_z;
  logic [REM_W-1:0] rem_x, rem_y, rem_z;

  // Voxel index terms
  logic [VOX_W-1:0] term_y_r, term_z_r;
  logic [VOX_W-1:0] voxel_sum;

  // Palette chain
  vppi_pkg::link_t links [PALETTE_SLOTS];

  // Output register
  logic               out_valid_r;
  logic               status_r, status_nxt;
  logic [IDX_W-1:0]   cidx_r, cidx_nxt;
  logic [CHUNK_W-1:0] chunk_x_r, chunk_y_r, chunk_z_r;
  logic [VOX_W-1:0]   voxel_r;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign run_last = (cnt_r == 8'(RUN_CYCLES - 1));
  assign out_free = !out_valid_r || out_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vppi_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_chan.action == vppi_pkg::ACT_PLACE) ? vppi_pkg::ST_RUN
                                                              : vppi_pkg::ST_DONE;
        end
      end
      vppi_pkg::ST_RUN: begin
        if (run_last) begin
          state_nxt = vppi_pkg::ST_SCALE;
        end
      end
      vppi_pkg::ST_SCALE: state_nxt = vppi_pkg::ST_DONE;
      vppi_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = vppi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vppi_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_chan.ready = 1'b0;
    div_load      = 1'b0;
    div_step      = 1'b0;
    commit        = 1'b0;
    case (state_r)
      vppi_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        div_load      = 1'b1;
      end
      vppi_pkg::ST_RUN:   div_step = (cnt_r < 8'(vppi_pkg::DIV_STEPS));
      vppi_pkg::ST_SCALE: commit = 1'b0;
      vppi_pkg::ST_DONE:  commit = out_free;
      default:            commit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vppi_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == vppi_pkg::ST_RUN) ? cnt_r + 8'd1 : 8'd0;
    end
  end

  // Capture the item and fold measure points into the minima
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= 16'sh7FFF;
      min_y_r <= 16'sh7FFF;
      min_z_r <= 16'sh7FFF;
    end else if (in_fire && in_chan.action == vppi_pkg::ACT_MEASURE) begin
      if (in_chan.pos_x < min_x_r) min_x_r <= in_chan.pos_x;
      if (in_chan.pos_y < min_y_r) min_y_r <= in_chan.pos_y;
      if (in_chan.pos_z < min_z_r) min_z_r <= in_chan.pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      place_r <= in_chan.action;
      probe_r <= {in_chan.red, in_chan.green, in_chan.blue};
    end
  end

  // Offset from the minima, biased to stay non-negative for floor division
  always_comb begin
    off_x = {in_chan.pos_x[POS_W-1], in_chan.pos_x} - {min_x_r[POS_W-1], min_x_r};
    off_y = {in_chan.pos_y[POS_W-1], in_chan.pos_y} - {min_y_r[POS_W-1], min_y_r};
    off_z = {in_chan.pos_z[POS_W-1], in_chan.pos_z} - {min_z_r[POS_W-1], min_z_r};
    dvd_x = {off_x[POS_W], off_x} + DIV_W'(BIAS);
    dvd_y = {off_y[POS_W], off_y} + DIV_W'(BIAS);
    dvd_z = {off_z[POS_W], off_z} + DIV_W'(BIAS);
  end

  vppi_div #(.CHUNK_SIZE(CHUNK_SIZE)) u_div_x (
    .clk(clk), .load(div_load), .step(div_step), .dividend(dvd_x),
    .quotient(quo_x), .remainder(rem_x)
  );
  vppi_div #(.CHUNK_SIZE(CHUNK_SIZE)) u_div_y (
    .clk(clk), .load(div_load), .step(div_step), .dividend(dvd_y),
    .quotient(quo_y), .remainder(rem_y)
  );
  vppi_div #(.CHUNK_SIZE(CHUNK_SIZE)) u_div_z (
    .clk(clk), .load(div_load), .step(div_step), .dividend(dvd_z),
    .quotient(quo_z), .remainder(rem_z)
  );

  // Scale the y and z remainders into the voxel index
  always_ff @(posedge clk) begin
    if (state_r == vppi_pkg::ST_SCALE) begin
      term_y_r <= VOX_W'({{(VOX_W-REM_W){1'b0}}, rem_y} * CS_M);
      term_z_r <= VOX_W'({{(VOX_W-REM_W){1'b0}}, rem_z} * CS2_M);
    end
  end

  assign voxel_sum = {{(VOX_W-REM_W){1'b0}}, rem_x} + term_y_r + term_z_r;

  // Palette cell row; slot 0 is reserved and has no cell
  assign links[0] = '0;

  for (genvar k = 1; k < PALETTE_SLOTS; k++) begin : g_cell
    vppi_cell #(.SLOT(k)) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .probe(probe_r),
      .used(used_r),
      .wr_en(append && (used_r == IDX_W'(k))),
      .link_in(links[k-1]),
      .link_out(links[k])
    );
  end

  // Resolve the search: hit, append or palette full
  always_comb begin
    append     = 1'b0;
    status_nxt = vppi_pkg::STAT_OK;
    cidx_nxt   = '0;
    if (place_r == vppi_pkg::ACT_PLACE) begin
      if (links[NCELLS].hit) begin
        cidx_nxt = links[NCELLS].idx;
      end else if (used_r < IDX_W'(PALETTE_SLOTS)) begin
        cidx_nxt = used_r;
        append   = commit;
      end else begin
        status_nxt = vppi_pkg::STAT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= IDX_W'(1);
    end else if (append) begin
      used_r <= used_r + IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= status_nxt;
      cidx_r   <= cidx_nxt;
      if (place_r == vppi_pkg::ACT_PLACE) begin
        chunk_x_r <= CHUNK_W'(quo_x - DIV_W'(BIAS_Q));
        chunk_y_r <= CHUNK_W'(quo_y - DIV_W'(BIAS_Q));
        chunk_z_r <= CHUNK_W'(quo_z - DIV_W'(BIAS_Q));
        voxel_r   <= voxel_sum;
      end else begin
        chunk_x_r <= '0;
        chunk_y_r <= '0;
        chunk_z_r <= '0;
        voxel_r   <= '0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.color_index = cidx_r;
  assign out_chan.chunk_x     = chunk_x_r;
  assign out_chan.chunk_y     = chunk_y_r;
  assign out_chan.chunk_z     = chunk_z_r;
  assign out_chan.voxel_index = voxel_r;

endmodule

[test/voxel_point_palette_indexer_core_tb.sv]
// Testbench for the voxel point palette indexer core: directed and random points vs a predictor.
`timescale 1ns / 1ps

module voxel_point_palette_indexer_core_tb;

  localparam int POS_W          = vppi_pkg::POS_W;
  localparam int CHAN_W         = vppi_pkg::CHAN_W;
  localparam int COLOR_W        = vppi_pkg::COLOR_W;
  localparam int IDX_W          = vppi_pkg::IDX_W;
  localparam int CHUNK_W        = vppi_pkg::CHUNK_W;
  localparam int VOX_W          = vppi_pkg::VOX_W;
  localparam int CHUNK          = vppi_pkg::CHUNK_SIZE_DEF;
  localparam int SLOTS          = vppi_pkg::PALETTE_SLOTS_DEF;
  localparam int RANDOM_POINTS  = 1230;
  localparam int IDLE_PCT       = 14;
  localparam int HOLD_CYCLES    = 1000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int TIMEOUT_CYCLES = 1200000;

  typedef struct {
    logic                    action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
  } point_t;

  typedef struct {
    logic               status;
    logic [IDX_W-1:0]   color_index;
    logic [CHUNK_W-1:0] chunk_x;
    logic [CHUNK_W-1:0] chunk_y;
    logic [CHUNK_W-1:0] chunk_z;
    logic [VOX_W-1:0]   voxel_index;
  } voxel_t;

  logic clk;
  logic rst_n;

  vppi_in_if  in_bus();
  vppi_out_if out_bus();

  voxel_point_palette_indexer_core #(
    .CHUNK_SIZE   (CHUNK),
    .PALETTE_SLOTS(SLOTS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  point_t pending_points[$];
  voxel_t expected_voxels[$];
  int     errors          = 0;
  int     points_accepted = 0;
  int     cycle_count     = 0;
  int     hold_left;
  bit     hold_done;

  // Predictor state: running minima and the color palette
  logic signed [POS_W-1:0] low_x, low_y, low_z;
  logic [COLOR_W-1:0]      palette [0:SLOTS-1];
  int                      palette_fill;

  // Stimulus-side view of the minima and the colors already offered
  int                 gen_low [3];
  logic [COLOR_W-1:0] color_pool[$];

  wire calm = (points_accepted >= 150) && (points_accepted < 300);

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Keep every input known from time zero
  initial begin
    in_bus.valid  = 1'b0;
    in_bus.action = vppi_pkg::ACT_MEASURE;
    in_bus.pos_x  = '0;
    in_bus.pos_y  = '0;
    in_bus.pos_z  = '0;
    in_bus.red    = '0;
    in_bus.green  = '0;
    in_bus.blue   = '0;
    out_bus.ready = 1'b0;
  end

  // Floor quotient by the chunk size with its non-negative remainder
  function automatic void split_offset(input int off, output int quot, output int rem);
    quot = off / CHUNK;
    rem  = off - quot * CHUNK;
    if (rem < 0) begin
      quot = quot - 1;
      rem  = rem + CHUNK;
    end
  endfunction

  // Work out the result of one point and advance the predictor state
  function automatic voxel_t predict_voxel(input point_t p);
    voxel_t             v;
    logic [COLOR_W-1:0] color;
    bit                 found;
    int                 qx, qy, qz, rx, ry, rz, vox;
    v.status      = vppi_pkg::STAT_OK;
    v.color_index = '0;
    v.chunk_x     = '0;
    v.chunk_y     = '0;
    v.chunk_z     = '0;
    v.voxel_index = '0;
    color = {p.red, p.green, p.blue};
    if (p.action == vppi_pkg::ACT_MEASURE) begin
      if (p.pos_x < low_x) low_x = p.pos_x;
      if (p.pos_y < low_y) low_y = p.pos_y;
      if (p.pos_z < low_z) low_z = p.pos_z;
    end else begin
      found = 1'b0;
      // Search only the slots already filled
      for (int i = 1; i < palette_fill; i++) begin
        if (!found && palette[i] == color) begin
          found         = 1'b1;
          v.color_index = IDX_W'(i);
        end
      end
      if (!found) begin
        if (palette_fill < SLOTS) begin
          palette[palette_fill] = color;
          v.color_index         = IDX_W'(palette_fill);
          palette_fill          = palette_fill + 1;
        end else begin
          v.status      = vppi_pkg::STAT_FULL;
          v.color_index = '0;
        end
      end
      split_offset(int'(p.pos_x) - int'(low_x), qx, rx);
      split_offset(int'(p.pos_y) - int'(low_y), qy, ry);
      split_offset(int'(p.pos_z) - int'(low_z), qz, rz);
      vox           = rx + ry * CHUNK + rz * CHUNK * CHUNK;
      v.chunk_x     = CHUNK_W'(qx);
      v.chunk_y     = CHUNK_W'(qy);
      v.chunk_z     = CHUNK_W'(qz);
      v.voxel_index = VOX_W'(vox);
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors = errors + 1;
    $display("error at cycle %0d: %s is 0x%0h, predicted 0x%0h", cycle_count, what, got, want);
  endtask

  // Stimulus helpers
  function automatic int clip_pos(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int place_coord(input int low);
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 75) return clip_pos(low + int'($urandom_range(2047)));
    if (pick < 88) return clip_pos(low - int'($urandom_range(64, 1)));
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int measure_coord(input int low);
    if ($urandom_range(99) < 96) return clip_pos(low + int'($urandom_range(200)) - 40);
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    if ($urandom_range(99) < 45 || color_pool.size() == 0) return COLOR_W'($urandom());
    return color_pool[$urandom_range(color_pool.size() - 1)];
  endfunction

  task automatic add_point(input logic act, input int x, input int y, input int z,
                           input logic [COLOR_W-1:0] rgb);
    point_t p;
    p.action = act;
    p.pos_x  = POS_W'(x);
    p.pos_y  = POS_W'(y);
    p.pos_z  = POS_W'(z);
    {p.red, p.green, p.blue} = rgb;
    if (act == vppi_pkg::ACT_MEASURE) begin
      if (x < gen_low[0]) gen_low[0] = x;
      if (y < gen_low[1]) gen_low[1] = y;
      if (z < gen_low[2]) gen_low[2] = z;
    end else begin
      color_pool.push_back(rgb);
    end
    pending_points.push_back(p);
  endtask

  // Driver: offer the next pending item, idle now and then
  always @(posedge clk) begin : driver
    point_t p;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_points.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        p = pending_points.pop_front();
        in_bus.valid  <= 1'b1;
        in_bus.action <= p.action;
        in_bus.pos_x  <= p.pos_x;
        in_bus.pos_y  <= p.pos_y;
        in_bus.pos_z  <= p.pos_z;
        in_bus.red    <= p.red;
        in_bus.green  <= p.green;
        in_bus.blue   <= p.blue;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && points_accepted >= 400) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict each accepted point, check each accepted result
  always @(posedge clk) begin : monitor
    point_t p;
    voxel_t want;
    if (!rst_n) begin
      low_x        = 16'sh7FFF;
      low_y        = 16'sh7FFF;
      low_z        = 16'sh7FFF;
      palette_fill = 1;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        p.action = in_bus.action;
        p.pos_x  = in_bus.pos_x;
        p.pos_y  = in_bus.pos_y;
        p.pos_z  = in_bus.pos_z;
        p.red    = in_bus.red;
        p.green  = in_bus.green;
        p.blue   = in_bus.blue;
        expected_voxels.push_back(predict_voxel(p));
        points_accepted <= points_accepted + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_voxels.size() == 0) begin
          report_mismatch("result with no point pending", 1, 0);
        end else begin
          want = expected_voxels.pop_front();
          if (out_bus.status !== want.status)
            report_mismatch("status", out_bus.status, want.status);
          if (out_bus.color_index !== want.color_index)
            report_mismatch("color_index", out_bus.color_index, want.color_index);
          if (out_bus.chunk_x !== want.chunk_x)
            report_mismatch("chunk_x", out_bus.chunk_x, want.chunk_x);
          if (out_bus.chunk_y !== want.chunk_y)
            report_mismatch("chunk_y", out_bus.chunk_y, want.chunk_y);
          if (out_bus.chunk_z !== want.chunk_z)
            report_mismatch("chunk_z", out_bus.chunk_z, want.chunk_z);
          if (out_bus.voxel_index !== want.voxel_index)
            report_mismatch("voxel_index", out_bus.voxel_index, want.voxel_index);
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("voxel_point_palette_indexer_core: mismatch");
      $finish;
    end
  end

  // Build the stimulus, run reset, wait for the block to drain
  initial begin : stimulus
    int made;
    int n_meas;
    int n_place;
    gen_low[0] = 32767;
    gen_low[1] = 32767;
    gen_low[2] = 32767;
    rst_n = 1'b0;

    // Place before any measure: offsets from the reset minima go negative
    add_point(vppi_pkg::ACT_PLACE, -32768, -32768, -32768, 24'h000000);
    add_point(vppi_pkg::ACT_PLACE, 32767, 32767, 32767, 24'hFFFFFF);
    add_point(vppi_pkg::ACT_PLACE, 0, -1, 12345, 24'h000000);
    // Measure at the top of the range leaves the minima alone
    add_point(vppi_pkg::ACT_MEASURE, 32767, 32767, 32767, 24'hFFFFFF);
    add_point(vppi_pkg::ACT_MEASURE, 100, -200, 3000, 24'h123456);
    add_point(vppi_pkg::ACT_MEASURE, 150, -300, 2990, 24'hABCDEF);
    // Offsets of zero, of a full chunk less one, of one chunk, and just below the minima
    add_point(vppi_pkg::ACT_PLACE, 100, -300, 2990, 24'h010203);
    add_point(vppi_pkg::ACT_PLACE, 131, -269, 3021, 24'hFFFFFF);
    add_point(vppi_pkg::ACT_PLACE, 132, -268, 3022, 24'h010203);
    add_point(vppi_pkg::ACT_PLACE, 99, -301, 2989, 24'hFEFEFE);
    add_point(vppi_pkg::ACT_PLACE, -32768, 32767, 0, 24'h000001);
    // Colors that differ in a single channel
    add_point(vppi_pkg::ACT_PLACE, 200, -100, 3100, 24'h000100);
    add_point(vppi_pkg::ACT_PLACE, 200, -100, 3100, 24'h010000);
    add_point(vppi_pkg::ACT_PLACE, 201, -99, 3101, 24'h000001);
    add_point(vppi_pkg::ACT_MEASURE, -1, -1, -1, 24'h000000);
    add_point(vppi_pkg::ACT_PLACE, -1, 500, -32768, 24'h800000);
    add_point(vppi_pkg::ACT_PLACE, 30000, -300, 2990, 24'h7F7F7F);
    add_point(vppi_pkg::ACT_MEASURE, 0, 0, 0, 24'h808080);
    add_point(vppi_pkg::ACT_PLACE, 63, -237, 3053, 24'h800000);

    // Random frames: a few measure points, then place points around the minima
    made = 0;
    while (made < RANDOM_POINTS) begin
      n_meas  = int'($urandom_range(4));
      n_place = int'($urandom_range(6, 1));
      repeat (n_meas)
        add_point(vppi_pkg::ACT_MEASURE, measure_coord(gen_low[0]),
                  measure_coord(gen_low[1]), measure_coord(gen_low[2]),
                  COLOR_W'($urandom()));
      repeat (n_place)
        add_point(vppi_pkg::ACT_PLACE, place_coord(gen_low[0]), place_coord(gen_low[1]),
                  place_coord(gen_low[2]), pick_color());
      made = made + n_meas + n_place;
    end

    // Widest offsets once the minima reach the bottom of the range
    add_point(vppi_pkg::ACT_MEASURE, -32768, -32768, -32768, 24'h000000);
    add_point(vppi_pkg::ACT_PLACE, 32767, 32767, 32767, 24'hFFFFFF);
    add_point(vppi_pkg::ACT_PLACE, -32768, -32768, -32768, 24'h5A5AA5);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_points.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_voxels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("voxel_point_palette_indexer_core: match");
    end else begin
      $display("voxel_point_palette_indexer_core: mismatch");
    end
    $finish;
  end

endmodule

[voxel_point_palette_indexer_core.f]
hdl/vppi_pkg.sv
hdl/vppi_if.sv
hdl/vppi_cell.sv
hdl/vppi_div.sv
hdl/voxel_point_palette_indexer_core.sv
test/voxel_point_palette_indexer_core_tb.sv
